### rtl/spq_pkg.sv
// shared types and constants for the strict priority ticket queues
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LINES   = 3;
  localparam int TICKET_BITS = 16;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LINE_W = $clog2(NUM_LINES);
  localparam int ADDR_W = $clog2(NUM_LINES * QUEUE_DEPTH);
  localparam int TOT_W  = $clog2(NUM_LINES * QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ISSUE      = 2'd0,
    ACT_ENQUEUE    = 2'd1,
    ACT_SERVE_LINE = 2'd2,
    ACT_SERVE_TOP  = 2'd3
  } action_e;

  // store access for one request
  typedef struct packed {
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [TICKET_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
  } mem_req_t;

  // result of one request, waiting for the store read data
  typedef struct packed {
    logic                              use_mem;
    logic [TICKET_BITS-1:0]            ticket;
    logic                              empty_serve;
    logic [LINE_W-1:0]                 served;
    logic                              dropped;
    logic [NUM_LINES-1:0][CNT_W-1:0]   count;
  } result_t;

endpackage

`default_nettype wire

### rtl/spq_store.sv
// ticket store: one circular buffer region per line, registered read
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_store (
  input  wire logic                            clk_i,
  input  wire spq_pkg::mem_req_t               req_i,
  output logic [spq_pkg::TICKET_BITS-1:0]      rdata_o
);
  import spq_pkg::*;

  logic [TICKET_BITS-1:0] mem_q [NUM_LINES*QUEUE_DEPTH];
  logic [TICKET_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // read data holds until the next serve
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/spq_ctrl.sv
// queue control: pointers, occupancy, ticket counter and the first result stage
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [1:0]                    line_class_i,
  input  wire logic [15:0]                   ticket_in_i,
  output spq_pkg::mem_req_t                  mem_req_o,
  output logic                               res_valid_o,
  output spq_pkg::result_t                   res_o,
  input  wire logic                          res_take_i
);
  import spq_pkg::*;

  logic [PTR_W-1:0]       head_q [NUM_LINES];
  logic [PTR_W-1:0]       tail_q [NUM_LINES];
  logic [CNT_W-1:0]       occ_q  [NUM_LINES];
  logic [CNT_W-1:0]       occ_d  [NUM_LINES];
  logic [TICKET_BITS-1:0] counter_q;
  logic                   res_valid_q;
  result_t                res_q;
  result_t                res_d;

  action_e           act;
  logic              accept;
  logic [LINE_W-1:0] line_sel;
  logic [LINE_W-1:0] top_line;
  logic [LINE_W-1:0] pop_line;
  logic              is_serve;
  logic              do_pop;
  logic              do_push;
  logic              full;

  assign act        = action_e'(action_i);
  assign in_stall_o = res_valid_q && !res_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx);
    logic [PTR_W-1:0] nxt;
    if (32'(idx) >= QUEUE_DEPTH - 1) nxt = '0;
    else                             nxt = idx + PTR_W'(1);
    return nxt;
  endfunction

  function automatic logic [ADDR_W-1:0] line_addr(input logic [LINE_W-1:0] ln,
                                                  input logic [PTR_W-1:0]  ptr);
    return ADDR_W'(ADDR_W'(ln) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(ptr);
  endfunction

  // out-of-range line selects the lowest line
  always_comb begin
    if (32'(line_class_i) >= NUM_LINES) line_sel = LINE_W'(NUM_LINES - 1);
    else                                line_sel = LINE_W'(line_class_i);
  end

  // first non-empty line, line 0 wins
  always_comb begin
    top_line = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (occ_q[i] != '0) top_line = LINE_W'(i);
    end
  end

  assign is_serve = (act == ACT_SERVE_LINE) || (act == ACT_SERVE_TOP);
  assign pop_line = (act == ACT_SERVE_TOP) ? top_line : line_sel;
  assign do_pop   = is_serve && (occ_q[pop_line] != '0);
  assign full     = 32'(occ_q[line_sel]) >= QUEUE_DEPTH;
  assign do_push  = (act == ACT_ENQUEUE) && !full;

  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      occ_d[i] = occ_q[i];
      if (do_push && (line_sel == LINE_W'(i))) occ_d[i] = occ_q[i] + CNT_W'(1);
      if (do_pop && (pop_line == LINE_W'(i)))  occ_d[i] = occ_q[i] - CNT_W'(1);
    end
  end

  always_comb begin
    res_d             = '0;
    res_d.use_mem     = do_pop;
    res_d.empty_serve = is_serve && !do_pop;
    res_d.dropped     = (act == ACT_ENQUEUE) && full;
    if (do_pop) res_d.served = pop_line;
    if (act == ACT_ISSUE) res_d.ticket = counter_q;
    for (int i = 0; i < NUM_LINES; i++) begin
      res_d.count[i] = occ_d[i];
    end
  end

  always_comb begin
    mem_req_o.wr_en   = accept && do_push;
    mem_req_o.wr_addr = line_addr(line_sel, tail_q[line_sel]);
    mem_req_o.wr_data = TICKET_BITS'(ticket_in_i);
    mem_req_o.rd_en   = accept && do_pop;
    mem_req_o.rd_addr = line_addr(pop_line, head_q[pop_line]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
      counter_q   <= TICKET_BITS'(1);
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        res_valid_q <= 1'b1;
        for (int i = 0; i < NUM_LINES; i++) begin
          occ_q[i] <= occ_d[i];
        end
        if (do_push) tail_q[line_sel] <= advance(tail_q[line_sel]);
        if (do_pop)  head_q[pop_line] <= advance(head_q[pop_line]);
        if (act == ACT_ISSUE) begin
          // zero is never issued
          if (counter_q == '1) counter_q <= TICKET_BITS'(1);
          else                 counter_q <= counter_q + TICKET_BITS'(1);
        end
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/spq_out.sv
// output register: merges the served ticket from the store and sums the occupancy
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_out (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             res_valid_i,
  input  wire spq_pkg::result_t                 res_i,
  input  wire logic [spq_pkg::TICKET_BITS-1:0]  rdata_i,
  output logic                                  res_take_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [15:0]                           ticket_out_o,
  output logic                                  empty_serve_o,
  output logic [1:0]                            served_class_o,
  output logic                                  dropped_o,
  output logic [4:0]                            count_high_o,
  output logic [4:0]                            count_mid_o,
  output logic [4:0]                            count_low_o,
  output logic [5:0]                            count_total_o
);
  import spq_pkg::*;

  logic             out_valid_q;
  logic [15:0]      ticket_q;
  logic             empty_serve_q;
  logic [1:0]       served_q;
  logic             dropped_q;
  logic [4:0]       high_q;
  logic [4:0]       mid_q;
  logic [4:0]       low_q;
  logic [5:0]       total_q;
  logic [TOT_W-1:0] total_d;
  logic [15:0]      ticket_d;

  // move up when the output slot is empty or being drained
  assign res_take_o = res_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    total_d = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      total_d = total_d + TOT_W'(res_i.count[i]);
    end
  end

  assign ticket_d = res_i.use_mem ? 16'(rdata_i) : 16'(res_i.ticket);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      ticket_q      <= ticket_d;
      empty_serve_q <= res_i.empty_serve;
      served_q      <= 2'(res_i.served);
      dropped_q     <= res_i.dropped;
      high_q        <= 5'(res_i.count[0]);
      mid_q         <= 5'(res_i.count[1]);
      low_q         <= (NUM_LINES > 2) ? 5'(res_i.count[2 % NUM_LINES]) : 5'd0;
      total_q       <= 6'(total_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ticket_out_o   = ticket_q;
  assign empty_serve_o  = empty_serve_q;
  assign served_class_o = served_q;
  assign dropped_o      = dropped_q;
  assign count_high_o   = high_q;
  assign count_mid_o    = mid_q;
  assign count_low_o    = low_q;
  assign count_total_o  = total_q;

endmodule

`default_nettype wire

### rtl/strict_priority_three_queue_top.sv
// Strict priority ticket queues: three FIFO lines of ticket numbers, line 0 highest.
// Each request issues a ticket, enqueues a ticket on a line, serves a given line
// or serves the highest non-empty line. Every request gives exactly one result
// with the served or issued ticket, empty/drop flags and the line occupancies.
// Channels: in_valid_i/in_stall_o carry action_i, line_class_i, ticket_in_i;
// out_valid_o/out_stall_i carry the result fields. A transfer happens on a clock
// edge with valid high and stall low.
// The edge that takes a request updates state, registers the first result stage and
// does the store access; the store read data then lands in the output register with
// the rest of the result once the output register is free. Throughput: one request
// per cycle while in_stall_o is low, with one store write or read per cycle.
// A stalled receiver holds the output register; one more request is still taken
// into the first result stage, after which in_stall_o rises.
// Reset: all lines empty, ticket counter at 1, no result pending. Store contents
// are not cleared; occupancy guards every read so stale entries never show.
// Depends on spq_pkg, spq_ctrl, spq_store, spq_out.
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_three_queue_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [1:0]  line_class_i,
  input  wire logic [15:0] ticket_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      ticket_out_o,
  output logic             empty_serve_o,
  output logic [1:0]       served_class_o,
  output logic             dropped_o,
  output logic [4:0]       count_high_o,
  output logic [4:0]       count_mid_o,
  output logic [4:0]       count_low_o,
  output logic [5:0]       count_total_o
);
  import spq_pkg::*;

  mem_req_t               mem_req;
  logic [TICKET_BITS-1:0] rdata;
  logic                   res_valid;
  result_t                res;
  logic                   res_take;

  spq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .line_class_i (line_class_i),
    .ticket_in_i  (ticket_in_i),
    .mem_req_o    (mem_req),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take)
  );

  spq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  spq_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_i          (res),
    .rdata_i        (rdata),
    .res_take_o     (res_take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ticket_out_o   (ticket_out_o),
    .empty_serve_o  (empty_serve_o),
    .served_class_o (served_class_o),
    .dropped_o      (dropped_o),
    .count_high_o   (count_high_o),
    .count_mid_o    (count_mid_o),
    .count_low_o    (count_low_o),
    .count_total_o  (count_total_o)
  );

endmodule

`default_nettype wire
